[design/jads_pkg.sv]
// Shared types, constants and register codes for the joystick average/deadzone/scaler.
`timescale 1ns / 1ps
package jads_pkg;

	// Number of readings averaged per result.
	localparam int SAMPLES = 8;
	localparam int NSAMP   = (SAMPLES < 1) ? 1 : SAMPLES;

	localparam int AXW    = 10;  // axis reading / result width
	localparam int PCTW   = 7;   // percentage register width
	localparam int SUMW   = 18;  // running sum width
	localparam int COLLW  = 8;   // readings-held counter width
	localparam int CMDW   = 2;
	localparam int IDXW   = 3;   // configuration index width
	localparam int SW     = 13;  // signed working width for thresholds and positions
	localparam int DIV_W  = 22;  // divider dividend / quotient width
	localparam int DVS_W  = 11;  // divider divisor width
	localparam int CNT_W  = $clog2(DIV_W + 1);
	localparam int PW     = SW + AXW + 1;  // signed product width in the lanes

	localparam int PCT_DIV = 100;

	// Reciprocal multiply and shift gives the exact truncated quotient for every
	// dividend below 2**(dividend width).
	localparam int PCT_DW = AXW + PCTW;  // center * percent, and the magnitude of rp
	localparam int PCT_SH = PCT_DW + $clog2(PCT_DIV);
	localparam int PCT_RW = PCT_DW + 1;
	localparam int PCT_PW = PCT_DW + PCT_RW;
	localparam int PCT_QW = PCT_PW - PCT_SH;  // quotient bits kept
	localparam logic [PCT_RW-1:0] PCT_RECIP =
		PCT_RW'(((longint'(1) << PCT_SH) + PCT_DIV - 1) / PCT_DIV);

	localparam int AVG_SH = SUMW + $clog2(NSAMP);
	localparam int AVG_RW = SUMW + 1;
	localparam int AVG_PW = SUMW + AVG_RW;
	localparam logic [AVG_RW-1:0] AVG_RECIP =
		AVG_RW'(((longint'(1) << AVG_SH) + NSAMP - 1) / NSAMP);

	localparam logic [AXW-1:0]   TOP_WIDE   = AXW'(1023);
	localparam logic [AXW-1:0]   TOP_NARROW = AXW'(255);
	localparam logic [CMDW-1:0]  CMD_NARROW = CMDW'(1);

	localparam logic [AXW-1:0]  RST_CENTER = AXW'(512);
	localparam logic [AXW-1:0]  RST_DELTA  = AXW'(200);
	localparam logic [PCTW-1:0] RST_PCT    = '0;

	typedef enum logic [IDXW-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_X_DELTA_POS,
		REG_X_DELTA_NEG,
		REG_Y_DELTA_POS,
		REG_Y_DELTA_NEG,
		REG_DEADZONE_PCT,
		REG_REVERSE_DEADZONE_PCT
	} jads_reg_t;

	// Per-axis input range taken from configuration.
	typedef struct packed {
		logic signed [SW-1:0] lo;
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] center;
	} jads_axis_t;

	// Thresholds shared by both lanes (all derived from X).
	typedef struct packed {
		logic signed [SW-1:0] dz_lo;
		logic signed [SW-1:0] dz_hi;
		logic signed [SW-1:0] rm;       // r + m, added to the axis minimum
		logic signed [SW-1:0] snap_hi;  // rp - m
	} jads_thr_t;

	typedef struct packed {
		logic avg_ok;
		logic res_ok;
	} jads_lane_stat_t;

endpackage

[design/jads_if.sv]
// Valid/ready channel interfaces for readings and scaled results.
`timescale 1ns / 1ps
interface jads_in_if import jads_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [AXW-1:0]  sample_x;
	logic [AXW-1:0]  sample_y;
	logic [CMDW-1:0] command;

	modport source (output valid, output sample_x, output sample_y, output command,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input command,
		output ready);
endinterface

interface jads_out_if import jads_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [AXW-1:0] axis_x;
	logic [AXW-1:0] axis_y;

	modport source (output valid, output axis_x, output axis_y, input ready);
	modport sink (input valid, input axis_x, input axis_y, output ready);
endinterface

[design/joystick_average_deadzone_scaler.sv]
// Top level: reading collection, X and Y lanes, threshold unit and result register.
// A reading that is collected or dropped leaves ready high.
// The reading after a full set starts a computation (averages, five threshold steps,
// snap and product, a mapping divide); ready stays low until the result enters the
// output register, longer while that register is held.
// Reset restores the default configuration and clears the sums and the count.
`timescale 1ns / 1ps
module joystick_average_deadzone_scaler import jads_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [IDXW-1:0] cfg_index,
	input  logic [AXW-1:0]  cfg_data,
	jads_in_if.sink         samples,
	jads_out_if.source      results
);

	typedef enum logic [1:0] {S_IDLE, S_AVG, S_MAP, S_OUT} state_t;

	state_t           state_q;
	logic [AXW-1:0]   center_x_q;
	logic [AXW-1:0]   center_y_q;
	logic [AXW-1:0]   x_delta_pos_q;
	logic [AXW-1:0]   x_delta_neg_q;
	logic [AXW-1:0]   y_delta_pos_q;
	logic [AXW-1:0]   y_delta_neg_q;
	logic [PCTW-1:0]  deadzone_pct_q;
	logic [PCTW-1:0]  reverse_deadzone_pct_q;

	logic [SUMW-1:0]  sum_x_q;
	logic [SUMW-1:0]  sum_y_q;
	logic [AXW-1:0]   prev_x_q;
	logic [AXW-1:0]   prev_y_q;
	logic [COLLW-1:0] collected_q;
	logic [CMDW-1:0]  cmd_q;
	logic             go_q;
	logic             map_q;
	logic             out_valid_q;
	logic [AXW-1:0]   axis_x_q;
	logic [AXW-1:0]   axis_y_q;

	jads_axis_t       axis_x;
	jads_axis_t       axis_y;
	jads_thr_t        thr;
	logic             thr_done;
	jads_lane_stat_t  stat_x;
	jads_lane_stat_t  stat_y;
	logic [AXW-1:0]   res_x;
	logic [AXW-1:0]   res_y;
	logic [AXW-1:0]   top;
	logic             take;
	logic             crossed_any;
	logic             load_out;

	function automatic logic crossed(input logic [AXW-1:0] before_v,
		input logic [AXW-1:0] now_v, input logic [AXW-1:0] c);
		crossed = (before_v < c && now_v > c) || (before_v > c && now_v < c);
	endfunction

	always_comb begin
		axis_x.center = $signed({{(SW-AXW){1'b0}}, center_x_q});
		axis_x.lo     = axis_x.center - $signed({{(SW-AXW){1'b0}}, x_delta_neg_q});
		axis_x.hi     = axis_x.center + $signed({{(SW-AXW){1'b0}}, x_delta_pos_q});
		axis_y.center = $signed({{(SW-AXW){1'b0}}, center_y_q});
		axis_y.lo     = axis_y.center - $signed({{(SW-AXW){1'b0}}, y_delta_neg_q});
		axis_y.hi     = axis_y.center + $signed({{(SW-AXW){1'b0}}, y_delta_pos_q});
		top           = (cmd_q == CMD_NARROW) ? TOP_NARROW : TOP_WIDE;
		take          = samples.valid && (state_q == S_IDLE);
		crossed_any   = crossed(prev_x_q, samples.sample_x, center_x_q)
			|| crossed(prev_y_q, samples.sample_y, center_y_q);
		load_out      = (state_q == S_OUT) && (!out_valid_q || results.ready);
	end

	jads_thr u_thr (
		.clk                  (clk),
		.arst_n               (arst_n),
		.start                (go_q),
		.center_x             (center_x_q),
		.deadzone_pct         (deadzone_pct_q),
		.reverse_deadzone_pct (reverse_deadzone_pct_q),
		.max_x                (axis_x.hi),
		.done                 (thr_done),
		.thr                  (thr)
	);

	jads_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.avg_start (go_q),
		.map_start (map_q),
		.sum       (sum_x_q),
		.axis      (axis_x),
		.thr       (thr),
		.top       (top),
		.inv       (1'b0),
		.stat      (stat_x),
		.res       (res_x)
	);

	jads_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.avg_start (go_q),
		.map_start (map_q),
		.sum       (sum_y_q),
		.axis      (axis_y),
		.thr       (thr),
		.top       (top),
		.inv       (1'b1),
		.stat      (stat_y),
		.res       (res_y)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q             <= RST_CENTER;
			center_y_q             <= RST_CENTER;
			x_delta_pos_q          <= RST_DELTA;
			x_delta_neg_q          <= RST_DELTA;
			y_delta_pos_q          <= RST_DELTA;
			y_delta_neg_q          <= RST_DELTA;
			deadzone_pct_q         <= RST_PCT;
			reverse_deadzone_pct_q <= RST_PCT;
		end else if (cfg_we) begin
			case (jads_reg_t'(cfg_index))
				REG_CENTER_X:             center_x_q             <= cfg_data;
				REG_CENTER_Y:             center_y_q             <= cfg_data;
				REG_X_DELTA_POS:          x_delta_pos_q          <= cfg_data;
				REG_X_DELTA_NEG:          x_delta_neg_q          <= cfg_data;
				REG_Y_DELTA_POS:          y_delta_pos_q          <= cfg_data;
				REG_Y_DELTA_NEG:          y_delta_neg_q          <= cfg_data;
				REG_DEADZONE_PCT:         deadzone_pct_q         <= cfg_data[PCTW-1:0];
				REG_REVERSE_DEADZONE_PCT: reverse_deadzone_pct_q <= cfg_data[PCTW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			collected_q <= '0;
			cmd_q       <= '0;
			go_q        <= 1'b0;
			map_q       <= 1'b0;
			out_valid_q <= 1'b0;
			axis_x_q    <= '0;
			axis_y_q    <= '0;
		end else begin
			go_q  <= 1'b0;
			map_q <= 1'b0;
			if (out_valid_q && results.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (collected_q < COLLW'(NSAMP)) begin
							if (collected_q != '0 && crossed_any) begin
								// drop the reading and restart collection
								collected_q <= '0;
								sum_x_q     <= '0;
								sum_y_q     <= '0;
							end else begin
								sum_x_q     <= sum_x_q + SUMW'(samples.sample_x);
								sum_y_q     <= sum_y_q + SUMW'(samples.sample_y);
								prev_x_q    <= samples.sample_x;
								prev_y_q    <= samples.sample_y;
								collected_q <= collected_q + COLLW'(1);
							end
						end else begin
							cmd_q   <= samples.command;
							go_q    <= 1'b1;
							state_q <= S_AVG;
						end
					end
				end
				S_AVG: begin
					if (!go_q && thr_done && stat_x.avg_ok && stat_y.avg_ok) begin
						map_q   <= 1'b1;
						state_q <= S_MAP;
					end
				end
				S_MAP: begin
					if (!map_q && stat_x.res_ok && stat_y.res_ok) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free
					if (load_out) begin
						axis_x_q    <= res_x;
						axis_y_q    <= res_y;
						out_valid_q <= 1'b1;
						collected_q <= '0;
						sum_x_q     <= '0;
						sum_y_q     <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign samples.ready  = (state_q == S_IDLE);
	assign results.valid  = out_valid_q;
	assign results.axis_x = axis_x_q;
	assign results.axis_y = axis_y_q;

endmodule

[design/jads_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module jads_div import jads_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot
);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] divisor_q;
	logic [DIV_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W-1:0] rem_next;

	always_comb begin
		trial    = {rem_q, quot_q[DIV_W-1]};
		fits     = (trial >= {1'b0, divisor_q});
		rem_next = fits ? DVS_W'(trial - {1'b0, divisor_q}) : trial[DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q     <= '0;
			divisor_q <= '0;
			quot_q    <= '0;
			cnt_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else if (start) begin
			rem_q     <= '0;
			divisor_q <= divisor;
			quot_q    <= dividend;
			cnt_q     <= CNT_W'(DIV_W);
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[DIV_W-2:0], fits};
			cnt_q  <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

[design/jads_thr.sv]
// Shared threshold unit: deadzone and edge snap limits from the X configuration.
`timescale 1ns / 1ps
module jads_thr import jads_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [AXW-1:0]       center_x,
	input  logic [PCTW-1:0]      deadzone_pct,
	input  logic [PCTW-1:0]      reverse_deadzone_pct,
	input  logic signed [SW-1:0] max_x,
	output logic                 done,
	output jads_thr_t            thr
);

	typedef enum logic [2:0] {T_IDLE, T_DZR, T_RP, T_M, T_SUM} tstate_t;

	tstate_t              state_q;
	logic                 done_q;
	jads_thr_t            thr_q;
	logic [PCT_DW-1:0]    prod_dz_q;
	logic [PCT_DW-1:0]    prod_r_q;
	logic signed [SW-1:0] dz_q;
	logic signed [SW-1:0] r_q;
	logic signed [SW-1:0] rp_q;
	logic [PCT_DW-1:0]    rp_mag_q;
	logic signed [SW-1:0] m_q;

	logic [PCT_PW-1:0]    scl_dz;
	logic [PCT_PW-1:0]    scl_r;
	logic [PCT_PW-1:0]    scl_m;
	logic signed [SW-1:0] cx;
	logic signed [SW-1:0] dz_now;
	logic signed [SW-1:0] r_now;
	logic signed [SW-1:0] rp_now;
	logic [SW-1:0]        rp_abs;
	logic signed [SW-1:0] m_abs;
	logic signed [SW-1:0] m_now;

	always_comb begin
		scl_dz = PCT_PW'(prod_dz_q) * PCT_PW'(PCT_RECIP);
		scl_r  = PCT_PW'(prod_r_q) * PCT_PW'(PCT_RECIP);
		scl_m  = PCT_PW'(rp_mag_q) * PCT_PW'(PCT_RECIP);
		cx     = $signed({{(SW-AXW){1'b0}}, center_x});
		dz_now = $signed({{(SW-PCT_QW){1'b0}}, scl_dz[PCT_SH +: PCT_QW]});
		r_now  = $signed({{(SW-PCT_QW){1'b0}}, scl_r[PCT_SH +: PCT_QW]});
		rp_now = max_x - r_q;
		rp_abs = rp_now[SW-1] ? $unsigned(-rp_now) : $unsigned(rp_now);
		m_abs  = $signed({{(SW-PCT_QW){1'b0}}, scl_m[PCT_SH +: PCT_QW]});
		// m truncates toward zero, so negate the magnitude quotient
		m_now  = rp_q[SW-1] ? -m_abs : m_abs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			done_q    <= 1'b0;
			thr_q     <= '0;
			prod_dz_q <= '0;
			prod_r_q  <= '0;
			dz_q      <= '0;
			r_q       <= '0;
			rp_q      <= '0;
			rp_mag_q  <= '0;
			m_q       <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (start) begin
						prod_dz_q <= center_x * deadzone_pct;
						prod_r_q  <= center_x * reverse_deadzone_pct;
						done_q    <= 1'b0;
						state_q   <= T_DZR;
					end
				end
				T_DZR: begin
					dz_q    <= dz_now;
					r_q     <= r_now;
					state_q <= T_RP;
				end
				T_RP: begin
					rp_q     <= rp_now;
					rp_mag_q <= PCT_DW'(rp_abs);
					state_q  <= T_M;
				end
				T_M: begin
					m_q     <= m_now;
					state_q <= T_SUM;
				end
				T_SUM: begin
					thr_q.dz_lo   <= cx - dz_q;
					thr_q.dz_hi   <= cx + dz_q;
					thr_q.rm      <= r_q + m_q;
					thr_q.snap_hi <= rp_q - m_q;
					done_q        <= 1'b1;
					state_q       <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign thr  = thr_q;

endmodule

[design/jads_lane.sv]
// One axis lane: average, deadzone and edge snap, then linear map with saturation.
`timescale 1ns / 1ps
module jads_lane import jads_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            avg_start,
	input  logic            map_start,
	input  logic [SUMW-1:0] sum,
	input  jads_axis_t      axis,
	input  jads_thr_t       thr,
	input  logic [AXW-1:0]  top,
	input  logic            inv,
	output jads_lane_stat_t stat,
	output logic [AXW-1:0]  res
);

	typedef enum logic [2:0] {L_IDLE, L_HOLD, L_SNAP, L_MUL, L_DIV} lstate_t;

	lstate_t              state_q;
	jads_lane_stat_t      stat_q;
	logic [AXW-1:0]       res_q;
	logic [AXW-1:0]       avg_q;
	logic signed [SW-1:0] v_q;
	logic                 neg_q;
	logic                 zero_q;
	logic                 div_start_q;
	logic [DIV_W-1:0]     div_dvd_q;
	logic [DVS_W-1:0]     div_dvs_q;

	logic                 div_done;
	logic [DIV_W-1:0]     quot;

	logic [AVG_PW-1:0]    avg_full;
	logic signed [SW-1:0] v0;
	logic signed [SW-1:0] v1;
	logic signed [SW-1:0] v2;
	logic signed [SW-1:0] snap_lo;
	logic signed [SW-1:0] diff;
	logic signed [SW-1:0] span;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] mag;
	logic [DIV_W-1:0]     q;
	logic                 over;
	logic [AXW-1:0]       res_next;

	jads_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd_q),
		.divisor  (div_dvs_q),
		.done     (div_done),
		.quot     (quot)
	);

	always_comb begin
		// average by reciprocal multiply and shift
		avg_full = AVG_PW'(sum) * AVG_PW'(AVG_RECIP);

		v0      = $signed({{(SW-AXW){1'b0}}, avg_q});
		snap_lo = axis.lo + thr.rm;
		v1      = (v0 >= thr.dz_lo && v0 <= thr.dz_hi) ? axis.center : v0;
		if (v1 <= snap_lo) begin
			v2 = axis.lo;
		end else if (v1 >= thr.snap_hi) begin
			v2 = axis.hi;
		end else begin
			v2 = v1;
		end

		diff = v_q - axis.lo;
		span = axis.hi - axis.lo;
		prod = $signed({{(PW-SW){diff[SW-1]}}, diff}) * $signed({{(PW-AXW){1'b0}}, top});
		mag  = prod[PW-1] ? -prod : prod;

		// zero span forces a zero quotient: output 0, or top on the inverted lane
		q    = zero_q ? '0 : quot;
		over = (q > {{(DIV_W-AXW){1'b0}}, top});
		if (!inv) begin
			res_next = neg_q ? '0 : (over ? top : q[AXW-1:0]);
		end else begin
			res_next = neg_q ? top : (over ? '0 : top - q[AXW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= L_IDLE;
			stat_q      <= '0;
			res_q       <= '0;
			avg_q       <= '0;
			v_q         <= '0;
			neg_q       <= 1'b0;
			zero_q      <= 1'b0;
			div_start_q <= 1'b0;
			div_dvd_q   <= '0;
			div_dvs_q   <= '0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (avg_start) begin
						avg_q   <= avg_full[AVG_SH +: AXW];
						stat_q  <= '{avg_ok: 1'b1, res_ok: 1'b0};
						state_q <= L_HOLD;
					end
				end
				L_HOLD: begin
					if (map_start) begin
						state_q <= L_SNAP;
					end
				end
				L_SNAP: begin
					v_q     <= v2;
					state_q <= L_MUL;
				end
				L_MUL: begin
					div_dvd_q   <= DIV_W'($unsigned(mag));
					div_dvs_q   <= DVS_W'($unsigned(span));
					neg_q       <= prod[PW-1];
					zero_q      <= (span == '0);
					div_start_q <= 1'b1;
					state_q     <= L_DIV;
				end
				L_DIV: begin
					if (!div_start_q && div_done) begin
						res_q         <= res_next;
						stat_q.res_ok <= 1'b1;
						state_q       <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign stat = stat_q;
	assign res  = res_q;

endmodule
